// ----- hdl/ptest_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptest_pkg
// shared constants and types for the primality tester
// ----------------------------------------------------------------------------
package ptest_pkg;

   localparam int NUM_WIDTH_DEF = 32;

   localparam logic [5:0] WITNESS_A = 6'd2;
   localparam logic [5:0] WITNESS_B = 6'd7;
   localparam logic [5:0] WITNESS_C = 6'd61;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_POW_MUL,
      ST_POW_MUL_WAIT,
      ST_POW_SQ,
      ST_POW_SQ_WAIT,
      ST_CHECK,
      ST_LOOP_SQ_WAIT,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/ptest_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptest_modmul
// shift-and-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ptest_modmul #(
   parameter int NUM_WIDTH = ptest_pkg::NUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] op_a,
   input  logic [NUM_WIDTH-1:0] op_b,
   input  logic [NUM_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] product
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] a_ff, a_in;
   logic [NUM_WIDTH-1:0] b_ff, b_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [NUM_WIDTH+1:0] dbl, dbl_red, add, add_red;

   always_comb begin
      dbl     = {1'b0, acc_ff, 1'b0};
      dbl_red = (dbl >= {2'b00, modulus}) ? dbl - {2'b00, modulus} : dbl;
      add     = dbl_red + (b_ff[NUM_WIDTH-1] ? {2'b00, a_ff} : '0);
      add_red = (add >= {2'b00, modulus}) ? add - {2'b00, modulus} : add;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         cnt_in  = CW'(NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = add_red[NUM_WIDTH-1:0];
         b_in   = {b_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- hdl/primality_test_32bit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primality_test_32bit
// deterministic miller-rabin test with witnesses 2, 7 and 61
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer a number; busy stays high until
// rsp_valid pulses for one cycle with rsp_prime. The receiver cannot
// stall. Trivial inputs go straight to the done state, from which rsp_valid
// is registered; an odd number takes up to three rounds of roughly
// 2*NUM_WIDTH modular products each, all computed in turn by the one
// shared shift-and-add multiplier.
// ----------------------------------------------------------------------------
module primality_test_32bit #(
   parameter int NUM_WIDTH = ptest_pkg::NUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [NUM_WIDTH-1:0] req_number,
   output logic                 rsp_valid,
   output logic                 rsp_prime
);

   localparam int SW = $clog2(NUM_WIDTH + 1);

   ptest_pkg::state_type state_ff, state_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in, d_ff, d_in, acc_ff, acc_in, sq_ff, sq_in;
   logic [SW-1:0]        s_ff, s_in, k_ff, k_in;
   logic [1:0]           wit_ff, wit_in;
   logic                 res_ff, res_in, vld_ff, vld_in;

   logic                 mm_start, mm_done;
   logic [NUM_WIDTH-1:0] mm_a, mm_b, mm_p, nm1, wval;

   ptest_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
      .clock(clock), .reset(reset), .start(mm_start), .op_a(mm_a), .op_b(mm_b),
      .modulus(n_ff), .done(mm_done), .product(mm_p)
   );

   assign nm1 = n_ff - 1'b1;

   always_comb begin
      case (wit_ff)
         2'd0:    wval = NUM_WIDTH'(ptest_pkg::WITNESS_A);
         2'd1:    wval = NUM_WIDTH'(ptest_pkg::WITNESS_B);
         default: wval = NUM_WIDTH'(ptest_pkg::WITNESS_C);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; d_in = d_ff; acc_in = acc_ff; sq_in = sq_ff;
      s_in = s_ff; k_in = k_ff; wit_in = wit_ff; res_in = res_ff;
      vld_in = 1'b0;
      mm_start = 1'b0; mm_a = acc_ff; mm_b = sq_ff;
      case (state_ff)
         ptest_pkg::ST_IDLE: begin
            if (start) begin
               n_in = req_number;
               wit_in = 2'd0;
               if (req_number == NUM_WIDTH'(2)) begin
                  res_in = 1'b1; state_in = ptest_pkg::ST_DONE;
               end else if (req_number < NUM_WIDTH'(2) || !req_number[0]) begin
                  res_in = 1'b0; state_in = ptest_pkg::ST_DONE;
               end else begin
                  state_in = ptest_pkg::ST_SETUP;
               end
            end
         end
         ptest_pkg::ST_SETUP: begin
            // d = n-1 with trailing zeros stripped one per cycle
            if (k_ff == '0 && s_ff == '0 && d_ff != nm1) begin
               d_in = nm1; s_in = '0; k_in = SW'(1);
            end else if (!d_ff[0]) begin
               d_in = d_ff >> 1; s_in = s_ff + 1'b1;
            end else begin
               // each witness is below n whenever its round runs
               acc_in = NUM_WIDTH'(1);
               sq_in = wval;
               state_in = ptest_pkg::ST_POW_MUL;
            end
         end
         ptest_pkg::ST_POW_MUL: begin
            if (d_ff == '0) begin
               state_in = ptest_pkg::ST_CHECK; k_in = '0;
            end else if (d_ff[0]) begin
               mm_start = 1'b1; state_in = ptest_pkg::ST_POW_MUL_WAIT;
            end else begin
               state_in = ptest_pkg::ST_POW_SQ;
            end
         end
         ptest_pkg::ST_POW_MUL_WAIT: begin
            if (mm_done) begin
               acc_in = mm_p; state_in = ptest_pkg::ST_POW_SQ;
            end
         end
         ptest_pkg::ST_POW_SQ: begin
            mm_a = sq_ff; mm_start = 1'b1; d_in = d_ff >> 1;
            state_in = ptest_pkg::ST_POW_SQ_WAIT;
         end
         ptest_pkg::ST_POW_SQ_WAIT: begin
            mm_a = sq_ff;
            if (mm_done) begin
               sq_in = mm_p; state_in = ptest_pkg::ST_POW_MUL;
            end
         end
         ptest_pkg::ST_CHECK: begin
            mm_a = acc_ff; mm_b = acc_ff;
            if ((k_ff == '0 && acc_ff == NUM_WIDTH'(1)) || acc_ff == nm1) begin
               state_in = ptest_pkg::ST_NEXT;
            end else if (k_ff + 1'b1 >= s_ff) begin
               res_in = 1'b0; state_in = ptest_pkg::ST_DONE;
            end else begin
               mm_start = 1'b1; state_in = ptest_pkg::ST_LOOP_SQ_WAIT;
            end
         end
         ptest_pkg::ST_LOOP_SQ_WAIT: begin
            mm_a = acc_ff; mm_b = acc_ff;
            if (mm_done) begin
               acc_in = mm_p; k_in = k_ff + 1'b1; state_in = ptest_pkg::ST_CHECK;
            end
         end
         ptest_pkg::ST_NEXT: begin
            d_in = '0; s_in = '0; k_in = '0;
            if (wit_ff == 2'd0 && n_ff > NUM_WIDTH'(7)) begin
               wit_in = 2'd1; state_in = ptest_pkg::ST_SETUP;
            end else if (wit_ff != 2'd2 && n_ff > NUM_WIDTH'(61)) begin
               wit_in = 2'd2; state_in = ptest_pkg::ST_SETUP;
            end else begin
               res_in = 1'b1; state_in = ptest_pkg::ST_DONE;
            end
         end
         ptest_pkg::ST_DONE: begin
            vld_in = 1'b1; state_in = ptest_pkg::ST_IDLE;
            d_in = '0; s_in = '0; k_in = '0;
         end
         default: state_in = ptest_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptest_pkg::ST_IDLE;
         vld_ff   <= 1'b0;
         d_ff     <= '0;
         s_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         d_ff     <= d_in;
         s_ff     <= s_in;
         k_ff     <= k_in;
      end
      n_ff   <= n_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      wit_ff <= wit_in;
      res_ff <= res_in;
   end

   assign busy      = (state_ff != ptest_pkg::ST_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_prime = res_ff;

endmodule
